// ----- rtl/gcbi_pkg.sv -----
// ----------------------------------------------------------------------------
// gcbi_pkg
// Constants and codes for the grid column bilinear interpolator.
// ----------------------------------------------------------------------------
package gcbi_pkg;

   localparam int GRID_CELLS = 1024;
   localparam int IDX_W      = $clog2(GRID_CELLS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ENTRY_W    = 96;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [31:0] NOT_FOUND_VALUE = 32'hFFFF_0000;

   localparam int FRAC_BITS = 16;

endpackage

// ----- rtl/grid_column_bilinear_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// grid_column_bilinear_interpolator_unit
// Grid table in one synchronous memory; queries scan it for the radius
// columns and straddling height pairs, then run three Q16.16 lerps through a
// shared serial divider and one multiplier.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, req_op, req_entry_* , req_query_* | in
//  rsp     | rsp_valid, rsp_stall, rsp_result_value, rsp_found       | out
//
//  A load writes the table entry.
//  A query makes up to three passes over the single read port of the table
//  (radius search, lower column, upper column), then three lerps through the
//  serial divider and the multiplier, and then loads the output register.
//  Reset clears control only; the table holds garbage until written.
//  req_stall is high while a query is in work; a result waits in the output
//  register under rsp_stall while the next request can already be taken.
// ----------------------------------------------------------------------------
module grid_column_bilinear_interpolator_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [9:0]               req_entry_index,
   input  logic signed [31:0]       req_entry_radius,
   input  logic signed [31:0]       req_entry_height,
   input  logic signed [31:0]       req_entry_value,
   input  logic signed [31:0]       req_query_radius,
   input  logic signed [31:0]       req_query_height,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_found
);
   import gcbi_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_COL   = 3'd2;
   localparam logic [2:0] S_DINIT = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_ADD   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   localparam logic [CNT_W-1:0] CELLS = CNT_W'(GRID_CELLS);
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(GRID_CELLS - 1);

   logic [2:0]               state_ff;
   logic [ENTRY_W-1:0]       mem [GRID_CELLS];
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic                     rd_vld_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic [CNT_W-1:0]         iss_ff;
   logic                     rd_en;
   logic                     kill;

   logic signed [31:0]       qr_ff, qh_ff, rlo_ff, rup_ff;
   logic signed [31:0]       prev_r_ff, prev_h_ff, prev_v_ff;
   logic signed [31:0]       ah0_ff, ah1_ff, av0_ff, av1_ff;
   logic signed [31:0]       bh0_ff, bh1_ff, bv0_ff, bv1_ff;
   logic signed [31:0]       a_ff, b_ff;
   logic                     col_sel_ff;
   logic [1:0]               lerp_ff;

   logic signed [31:0]       cur_r, cur_h, cur_v, col;
   logic                     hit, pair, last_entry;

   logic signed [31:0]       x0, x1, x, v0, v1;
   logic signed [32:0]       num, den;
   logic [32:0]              un, ud;
   logic [32:0]              ud_ff, rem_ff;
   logic [16:0]              q_ff;
   logic [4:0]               cnt_ff;
   logic [33:0]              sh;
   logic signed [32:0]       dv_ff;
   logic signed [31:0]       v0_ff;
   logic signed [50:0]       prod_ff;
   logic signed [34:0]       sum;

   logic                     rsp_valid_ff, found_ff;
   logic signed [31:0]       res_ff;
   logic                     done_found_ff;
   logic signed [31:0]       done_value_ff;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_result_value = res_ff;

   assign cur_r = rd_data_ff[95:64];
   assign cur_h = rd_data_ff[63:32];
   assign cur_v = rd_data_ff[31:0];
   assign col   = col_sel_ff ? rup_ff : rlo_ff;
   assign last_entry = (rd_idx_ff == LAST);
   assign hit  = (cur_r >= qr_ff);
   assign pair = (rd_idx_ff != '0) && (prev_r_ff == col) && (cur_r == col) &&
                 (((cur_h < qh_ff) && (prev_h_ff > qh_ff)) ||
                  ((cur_h > qh_ff) && (prev_h_ff < qh_ff)));

   // stop issuing table reads when a scan pass ends
   always_comb begin
      kill = 1'b0;
      if (rd_vld_ff) begin
         if (state_ff == S_SCAN) kill = hit || last_entry;
         if (state_ff == S_COL)  kill = pair || last_entry;
      end
   end
   assign rd_en = ((state_ff == S_SCAN) || (state_ff == S_COL)) &&
                  (iss_ff < CELLS) && !kill;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall && (req_op == OP_LOAD) &&
          ({1'b0, req_entry_index} < CELLS)) begin
         mem[req_entry_index[IDX_W-1:0]] <=
            {req_entry_radius, req_entry_height, req_entry_value};
      end
      if (rd_en) begin
         rd_data_ff <= mem[iss_ff[IDX_W-1:0]];
         rd_idx_ff  <= iss_ff[IDX_W-1:0];
      end
   end

   // lerp operands: two height lerps, then one in radius
   always_comb begin
      unique case (lerp_ff)
         2'd0:    begin x0 = ah0_ff; x1 = ah1_ff; x = qh_ff; v0 = av0_ff; v1 = av1_ff; end
         2'd1:    begin x0 = bh0_ff; x1 = bh1_ff; x = qh_ff; v0 = bv0_ff; v1 = bv1_ff; end
         default: begin x0 = rlo_ff; x1 = rup_ff; x = qr_ff; v0 = a_ff;   v1 = b_ff;   end
      endcase
      num = 33'(x) - 33'(x0);
      den = 33'(x1) - 33'(x0);
      un  = num[32] ? 33'(-num) : num;
      ud  = den[32] ? 33'(-den) : den;
   end

   assign sh  = {rem_ff, 1'b0};
   assign sum = 35'(v0_ff) + 35'(prod_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         col_sel_ff   <= 1'b0;
         lerp_ff      <= 2'd0;
         cnt_ff       <= '0;
      end else begin
         rd_vld_ff <= rd_en;
         if (rd_en) iss_ff <= iss_ff + 1'b1;
         // load the output register once it is free, else drop a taken result
         if ((state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            found_ff     <= done_found_ff;
            res_ff       <= done_value_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_vld_ff) begin
            prev_r_ff <= cur_r;
            prev_h_ff <= cur_h;
            prev_v_ff <= cur_v;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_op == OP_QUERY) begin
                  qr_ff    <= req_query_radius;
                  qh_ff    <= req_query_height;
                  iss_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (rd_vld_ff) begin
                  if (hit && rd_idx_ff != '0) begin
                     rlo_ff     <= prev_r_ff;
                     rup_ff     <= cur_r;
                     col_sel_ff <= 1'b0;
                     iss_ff     <= '0;
                     state_ff   <= S_COL;
                  end else if (hit || last_entry) begin
                     done_found_ff <= 1'b0;
                     done_value_ff <= NOT_FOUND_VALUE;
                     state_ff      <= S_OUT;
                  end
               end
            end
            S_COL: begin
               if (rd_vld_ff) begin
                  if (pair) begin
                     if (!col_sel_ff) begin
                        ah0_ff <= prev_h_ff; ah1_ff <= cur_h;
                        av0_ff <= prev_v_ff; av1_ff <= cur_v;
                        col_sel_ff <= 1'b1;
                        iss_ff     <= '0;
                     end else begin
                        bh0_ff <= prev_h_ff; bh1_ff <= cur_h;
                        bv0_ff <= prev_v_ff; bv1_ff <= cur_v;
                        lerp_ff  <= 2'd0;
                        state_ff <= S_DINIT;
                     end
                  end else if (last_entry) begin
                     done_found_ff <= 1'b0;
                     done_value_ff <= NOT_FOUND_VALUE;
                     state_ff      <= S_OUT;
                  end
               end
            end
            S_DINIT: begin
               ud_ff <= ud;
               if (un >= ud) begin
                  q_ff   <= 17'd1;
                  rem_ff <= un - ud;
               end else begin
                  q_ff   <= 17'd0;
                  rem_ff <= un;
               end
               v0_ff    <= v0;
               dv_ff    <= 33'(v1) - 33'(v0);
               cnt_ff   <= 5'(FRAC_BITS);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (sh >= {1'b0, ud_ff}) begin
                  rem_ff <= 33'(sh - {1'b0, ud_ff});
                  q_ff   <= {q_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= sh[32:0];
                  q_ff   <= {q_ff[15:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == 5'd1) state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= 51'(dv_ff * $signed({1'b0, q_ff}));
               state_ff <= S_ADD;
            end
            S_ADD: begin
               unique case (lerp_ff)
                  2'd0: begin a_ff <= sum[31:0]; lerp_ff <= 2'd1; state_ff <= S_DINIT; end
                  2'd1: begin b_ff <= sum[31:0]; lerp_ff <= 2'd2; state_ff <= S_DINIT; end
                  default: begin
                     done_value_ff <= sum[31:0];
                     done_found_ff <= 1'b1;
                     state_ff      <= S_OUT;
                  end
               endcase
            end
            default: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_not_found_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_result_value == NOT_FOUND_VALUE))
      else $error("not-found result carries wrong value");
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (q_ff <= 17'h10000))
      else $error("interpolation fraction above one");
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(state_ff) == S_SCAN || $past(state_ff) == S_COL))
      else $error("table read outside a scan");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> req_stall)
      else $error("request taken during interpolation");
`endif

endmodule
